[sv/rpd_pkg.sv]
// ---------------------------------------------------------------------------
// rpd_pkg: shared definitions for the response packet deframer
// Command, status and register codes, frame constants and the result record.
// ---------------------------------------------------------------------------
package rpd_pkg;

  // Input commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_BAD_HDR  = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

  // Frame constants
  localparam logic [7:0] HDR_BYTE0      = 8'hEF;
  localparam logic [7:0] HDR_BYTE1      = 8'h01;
  localparam logic [7:0] KIND_ACK       = 8'h07;
  localparam logic [7:0] CONFIRM_NONE   = 8'hFF;
  localparam int         HDR_BYTES      = 9;
  localparam int         CONF_MIN_BYTES = 12;

  // Configuration port
  localparam int         PADDR_W         = 3;
  localparam int         PDATA_W         = 32;
  localparam logic       REG_IDX_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

  localparam int MAX_FRAME_BYTES_DEF = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  confirm_code;
    logic [31:0] device_address;
    logic [7:0]  packet_kind;
    logic [15:0] declared_length;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [6:0]  bytes_received;
  } rpd_result_t;

endpackage

[sv/rpd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// rpd_cfg_regs: configuration register file
// APB-style access to the timeout register; zero wait states.
// ---------------------------------------------------------------------------
module rpd_cfg_regs
  import rpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [15:0]        timeout_limit
);

  logic wr_en;
  logic sel_timeout;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite;
  assign sel_timeout = (paddr[PADDR_W-1] == REG_IDX_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (wr_en && sel_timeout) begin
      timeout_limit <= pwdata[15:0];
    end
  end

  assign prdata = sel_timeout ? {(PDATA_W - 16)'(0), timeout_limit} : '0;

endmodule

[sv/rpd_frame_core.sv]
// ---------------------------------------------------------------------------
// rpd_frame_core: frame state and per-beat update
// Holds the reception state and computes the next state and result for one
// registered beat in a single pass.
// ---------------------------------------------------------------------------
module rpd_frame_core
  import rpd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  input  logic [15:0] timeout_limit,
  output logic        res_fire,
  output rpd_result_t result
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [CNT_W-1:0] POS_HDR0  = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_HDR1  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_ADDR0 = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_ADDR1 = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_ADDR2 = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_ADDR3 = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_KIND  = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_LENH  = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_LENL  = CNT_W'(8);
  localparam logic [CNT_W-1:0] POS_CONF  = CNT_W'(9);
  localparam logic [CNT_W-1:0] POS_W0H   = CNT_W'(10);
  localparam logic [CNT_W-1:0] POS_W0L   = CNT_W'(11);
  localparam logic [CNT_W-1:0] POS_W1H   = CNT_W'(12);
  localparam logic [CNT_W-1:0] POS_W1L   = CNT_W'(13);
  localparam logic [CNT_W-1:0] HDR_CNT   = CNT_W'(HDR_BYTES);
  localparam logic [CNT_W-1:0] CONF_CNT  = CNT_W'(CONF_MIN_BYTES);

  // Control state
  logic             receiving, receiving_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      elapsed_ms, elapsed_ms_next;
  logic             header_ok, header_ok_next;
  logic [CNT_W-1:0] frame_total, frame_total_next;
  // Captured fields
  logic [31:0]      frame_address, frame_address_next;
  logic [7:0]       frame_kind, frame_kind_next;
  logic [15:0]      frame_length, frame_length_next;
  logic [7:0]       frame_confirm, frame_confirm_next;
  logic [15:0]      word0, word0_next;
  logic [15:0]      word1, word1_next;

  logic [16:0]      total_sum;
  logic [1:0]       status;

  always_comb begin
    receiving_next     = receiving;
    byte_count_next    = byte_count;
    elapsed_ms_next    = elapsed_ms;
    header_ok_next     = header_ok;
    frame_total_next   = frame_total;
    frame_address_next = frame_address;
    frame_kind_next    = frame_kind;
    frame_length_next  = frame_length;
    frame_confirm_next = frame_confirm;
    word0_next         = word0;
    word1_next         = word1;
    total_sum          = '0;
    res_fire           = 1'b0;
    status             = STATUS_OK;

    if (step) begin
      unique case (command)
        CMD_START: begin
          receiving_next     = 1'b1;
          byte_count_next    = '0;
          elapsed_ms_next    = '0;
          header_ok_next     = 1'b0;
          frame_total_next   = '0;
          frame_address_next = '0;
          frame_kind_next    = '0;
          frame_length_next  = '0;
          frame_confirm_next = '0;
          word0_next         = '0;
          word1_next         = '0;
          if (timeout_limit == 16'd0) begin
            res_fire = 1'b1;
            status   = STATUS_TIMEOUT;
          end
        end
        CMD_TICK: begin
          if (receiving) begin
            elapsed_ms_next = elapsed_ms + 16'd1;
            if (elapsed_ms_next >= timeout_limit) begin
              res_fire = 1'b1;
              status   = STATUS_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          if (receiving) begin
            byte_count_next = byte_count + CNT_W'(1);
            unique case (byte_count)
              POS_HDR0: header_ok_next = (byte_value == HDR_BYTE0);
              POS_HDR1: header_ok_next = header_ok && (byte_value == HDR_BYTE1);
              POS_ADDR0, POS_ADDR1, POS_ADDR2, POS_ADDR3:
                frame_address_next = {frame_address[23:0], byte_value};
              POS_KIND: frame_kind_next = byte_value;
              POS_LENH: frame_length_next = {byte_value, 8'd0};
              POS_LENL: frame_length_next = {frame_length[15:8], byte_value};
              POS_CONF: frame_confirm_next = byte_value;
              POS_W0H:  word0_next = {byte_value, 8'd0};
              POS_W0L:  word0_next = {word0[15:8], byte_value};
              POS_W1H:  word1_next = {byte_value, 8'd0};
              POS_W1L:  word1_next = {word1[15:8], byte_value};
              default: ;
            endcase

            // Header and length verdict at the ninth byte
            total_sum = 17'(HDR_BYTES) + {1'b0, frame_length_next};
            if (byte_count_next == HDR_CNT) begin
              if (!header_ok_next) begin
                res_fire = 1'b1;
                status   = STATUS_BAD_HDR;
              end else if (total_sum > 17'(MAX_FRAME_BYTES)) begin
                res_fire = 1'b1;
                status   = STATUS_TOO_LONG;
              end else begin
                frame_total_next = CNT_W'(total_sum);
              end
            end
            if (!res_fire && byte_count_next >= HDR_CNT &&
                byte_count_next >= frame_total_next) begin
              res_fire = 1'b1;
              status   = STATUS_OK;
            end
          end
        end
        default: ;
      endcase
      if (res_fire) begin
        receiving_next = 1'b0;
      end
    end
  end

  always_comb begin
    result.status          = status;
    result.confirm_code    = (status == STATUS_OK && byte_count_next >= CONF_CNT &&
                              frame_kind_next == KIND_ACK) ? frame_confirm_next
                                                           : CONFIRM_NONE;
    result.device_address  = frame_address_next;
    result.packet_kind     = frame_kind_next;
    result.declared_length = frame_length_next;
    result.first_word      = word0_next;
    result.second_word     = word1_next;
    result.bytes_received  = 7'(byte_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      byte_count  <= '0;
      elapsed_ms  <= '0;
      header_ok   <= 1'b0;
      frame_total <= '0;
    end else begin
      receiving   <= receiving_next;
      byte_count  <= byte_count_next;
      elapsed_ms  <= elapsed_ms_next;
      header_ok   <= header_ok_next;
      frame_total <= frame_total_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_address <= frame_address_next;
    frame_kind    <= frame_kind_next;
    frame_length  <= frame_length_next;
    frame_confirm <= frame_confirm_next;
    word0         <= word0_next;
    word1         <= word1_next;
  end

endmodule

[sv/response_packet_deframer_unit.sv]
// ---------------------------------------------------------------------------
// response_packet_deframer_unit: serial response frame deframer
// Collects one response frame per start beat and reports its status,
// header fields and first two payload words.
// ---------------------------------------------------------------------------
// Rate and timing: one input beat per clock, sustained while the result side
// keeps up. A beat lands in the input register at its accept edge and is
// processed by the frame core once the output register is empty or being
// taken; a result it closes is in the output register from the next edge,
// where out_valid rises and the result waits to be taken. The held beat
// only moves into the core while the output register is empty or being
// taken, so a result left waiting stalls the input: one more beat can
// still be taken into the input register, then in_ready stays low until
// the result is taken. Beat commands: byte, millisecond tick, start. A
// start opens a fresh reception (dropping any open one silently); each
// reception that is not dropped ends with exactly one result: ok,
// timeout, bad header or too long. The checksum is not checked. The user
// must write timeout_limit (register 0, reset 1000) only while the block
// is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module response_packet_deframer_unit
  import rpd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         byte_value,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         confirm_code,
  output logic [31:0]        device_address,
  output logic [7:0]         packet_kind,
  output logic [15:0]        declared_length,
  output logic [15:0]        first_word,
  output logic [15:0]        second_word,
  output logic [6:0]         bytes_received
);

  logic [15:0] timeout_limit;

  // input register
  logic        in_held;
  logic [1:0]  command_q;
  logic [7:0]  byte_q;

  // core handshake
  logic        step;
  logic        res_fire;
  rpd_result_t res_next;
  rpd_result_t res_q;

  rpd_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .timeout_limit(timeout_limit)
  );

  // Held beat moves on when the result slot is free or drains this cycle.
  assign step     = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      command_q <= command;
      byte_q    <= byte_value;
    end
  end

  rpd_frame_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .command      (command_q),
    .byte_value   (byte_q),
    .timeout_limit(timeout_limit),
    .res_fire     (res_fire),
    .result       (res_next)
  );

  // output register: a fresh result overrides the drain of the old one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_fire) begin
      res_q <= res_next;
    end
  end

  assign status          = res_q.status;
  assign confirm_code    = res_q.confirm_code;
  assign device_address  = res_q.device_address;
  assign packet_kind     = res_q.packet_kind;
  assign declared_length = res_q.declared_length;
  assign first_word      = res_q.first_word;
  assign second_word     = res_q.second_word;
  assign bytes_received  = res_q.bytes_received;

endmodule

[sv/rpd_checker.sv]
// ---------------------------------------------------------------------------
// rpd_checker: port-level checks for the deframer
// Watches the result channel and reset behavior at the top-level ports.
// ---------------------------------------------------------------------------
module rpd_checker
  import rpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  confirm_code,
  input logic [7:0]  packet_kind,
  input logic [15:0] first_word,
  input logic [6:0]  bytes_received
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(confirm_code) && $stable(bytes_received))
    else $error("result beat changed while stalled");

  // confirm code is only passed through on an ok acknowledgement
  a_confirm: assert property (@(posedge clk) disable iff (rst)
    out_valid && confirm_code != CONFIRM_NONE |->
      status == STATUS_OK && packet_kind == KIND_ACK)
    else $error("confirm code on a non-ack or failed frame");

  // header verdicts are issued at the ninth byte
  a_hdr_at_nine: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_BAD_HDR || status == STATUS_TOO_LONG) |->
      bytes_received == 7'(HDR_BYTES) && first_word == 16'd0)
    else $error("header verdict not at byte nine");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind response_packet_deframer_unit rpd_checker u_rpd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .confirm_code  (confirm_code),
  .packet_kind   (packet_kind),
  .first_word    (first_word),
  .bytes_received(bytes_received)
);
